// ===== src/q4bdp_pkg.sv =====
// Package for the 4-bit block-quantized dot product: shared types,
// widths and the half-precision to Q8.24 scale conversion.
// Has no dependencies; every module of the block imports it.
package q4bdp_pkg;

  localparam int LANES      = 2;
  localparam int NIB_W      = 4;
  localparam int ACT_W      = 16;
  localparam int HALF_W     = 16;
  localparam int PROD_W     = 20;
  localparam int PART_W     = 21;
  localparam int SCALE_W    = 32;
  localparam int TERM_W     = PART_W + SCALE_W;
  localparam int ACC_W      = 64;
  localparam int KLEN_W     = 13;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic [NIB_W-1:0]  WEIGHT_OFFSET = 4'd8;
  localparam logic [4:0]        EXP_SPECIAL   = 5'd31;
  localparam logic [4:0]        EXP_SUBNORMAL = 5'd0;
  localparam logic [40:0]       SCALE_LIMIT   = 41'h0_7FFF_FFFF;

  // Pipeline control that rides along with each item.
  typedef struct packed {
    logic valid;
    logic last;
    logic flag;
  } ctrl_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale;
    logic                      flag;
  } scale_t;

  // Exact conversion of a half value to signed Q8.24, saturating at
  // +/-(2^31-1). NaN gives zero; NaN and saturation raise the flag.
  function automatic scale_t half_to_q824(input logic [HALF_W-1:0] h);
    logic [4:0]         e;
    logic [9:0]         m;
    logic [40:0]        full;
    logic [SCALE_W-1:0] mag;
    scale_t             r;
    e    = h[14:10];
    m    = h[9:0];
    full = 41'({1'b1, m}) << (e - 5'd1);
    r.flag = 1'b0;
    if (e == EXP_SPECIAL) begin
      r.flag = 1'b1;
      mag    = (m != 10'd0) ? '0 : SCALE_LIMIT[SCALE_W-1:0];
    end else if (e == EXP_SUBNORMAL) begin
      mag = SCALE_W'(m);
    end else if (full > SCALE_LIMIT) begin
      r.flag = 1'b1;
      mag    = SCALE_LIMIT[SCALE_W-1:0];
    end else begin
      mag = full[SCALE_W-1:0];
    end
    r.scale = h[15] ? -$signed(mag) : $signed(mag);
    return r;
  endfunction

endpackage

// ===== src/q4_block_dot_product.sv =====
// Top level of the 4-bit block-quantized dot product; uses q4bdp_pkg,
// q4bdp_lane, q4bdp_merge and q4bdp_accum.
// The result is valid once the last item has passed the lane, merge and result registers.
// Throughput: one item per cycle unless a result waits on a stalled output, set by the accumulator add.
// Reset (rst, synchronous): empties the pipeline, clears sum, count and flag,
// and sets k_length to 4096.
module q4_block_dot_product #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: k_length write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [q4bdp_pkg::KLEN_W-1:0]         cfg_data,
  // Input stream. tdata from bit 0: packed_weights[7:0], act_lo[23:8],
  // act_hi[39:24], block_scale[55:40].
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [q4bdp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result stream. tdata: dot_value[63:0]. tuser: overflowed[0].
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [q4bdp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser
);
  import q4bdp_pkg::*;

  // Common width for lengths so both the 13-bit register and the
  // parameter limit compare without loss.
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int CMP_W = (LEN_W > KLEN_W) ? LEN_W : KLEN_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_LENGTH);

  logic [KLEN_W-1:0] k_length;

  // The item counter, length clamp and lane masks sit ahead of the lanes.
  logic [CMP_W-1:0] item_count;
  logic [CMP_W-1:0] item_count_next;
  logic [CMP_W-1:0] len;
  logic [CMP_W:0]   total;
  logic [CMP_W:0]   idx_lo;
  logic [CMP_W:0]   idx_hi;
  logic [CMP_W:0]   count_inc;
  logic             lane_valid [LANES];
  logic             any_valid;
  logic             is_last;
  logic             accept;
  logic             ce;

  logic [7:0]        packed_weights;
  logic [ACT_W-1:0]  act_lo;
  logic [ACT_W-1:0]  act_hi;
  logic [HALF_W-1:0] block_scale;
  logic [ACT_W-1:0]  lane_act [LANES];
  logic [NIB_W-1:0]  lane_nib [LANES];

  scale_t                    conv;
  logic signed [SCALE_W-1:0] s1_scale;
  ctrl_t                     s1_ctrl;
  logic signed [PROD_W-1:0]  s1_prod [LANES];
  logic signed [TERM_W-1:0]  s2_term;
  ctrl_t                     s2_ctrl;
  logic                      res_valid;
  logic [ACC_W-1:0]          dot_value;
  logic                      overflowed;

  assign packed_weights = s_axis_tdata[7:0];
  assign act_lo         = s_axis_tdata[23:8];
  assign act_hi         = s_axis_tdata[39:24];
  assign block_scale    = s_axis_tdata[55:40];

  // The whole pipeline moves together and only holds while a finished
  // result waits on a stalled output; s_axis_tready follows m_axis_tready
  // combinationally then, and items keep entering while the sink is ready.
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_length <= KLEN_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      k_length <= cfg_data;
    end
  end

  // A length above the limit is clamped; a zero length still runs one
  // block of sixteen items with every element ignored.
  always_comb begin
    len = (CMP_W'(k_length) > MAX_LEN) ? MAX_LEN : CMP_W'(k_length);
    if (len == '0) begin
      total = (CMP_W + 1)'(16);
    end else begin
      total = ((CMP_W + 1)'(len) + (CMP_W + 1)'(31)) >> 5 << 4;
    end
    idx_lo    = {item_count, 1'b0};
    idx_hi    = {item_count, 1'b1};
    count_inc = (CMP_W + 1)'(item_count) + 1'b1;
    lane_valid[0] = idx_lo < (CMP_W + 1)'(len);
    lane_valid[1] = idx_hi < (CMP_W + 1)'(len);
    any_valid = lane_valid[0] || lane_valid[1];
    is_last   = count_inc >= total;
    item_count_next = is_last ? '0 : count_inc[CMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
    end else if (accept) begin
      item_count <= item_count_next;
    end
  end

  // Scale conversion is registered beside the lane products. Flags from
  // an item with no valid element are dropped.
  assign conv = half_to_q824(block_scale);

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_scale <= conv.scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (ce) begin
      s1_ctrl.valid <= accept;
      s1_ctrl.last  <= is_last;
      s1_ctrl.flag  <= conv.flag & any_valid;
    end
  end

  assign lane_nib[0] = packed_weights[3:0];
  assign lane_nib[1] = packed_weights[7:4];
  assign lane_act[0] = act_lo;
  assign lane_act[1] = act_hi;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q4bdp_lane u_lane (
      .clk        (clk),
      .ce         (ce),
      .lane_valid (lane_valid[g]),
      .nibble     (lane_nib[g]),
      .act        ($signed(lane_act[g])),
      .prod       (s1_prod[g])
    );
  end

  q4bdp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .lane_prod (s1_prod),
    .scale     (s1_scale),
    .ctrl_in   (s1_ctrl),
    .term      (s2_term),
    .ctrl_out  (s2_ctrl)
  );

  q4bdp_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .term       (s2_term),
    .ctrl_in    (s2_ctrl),
    .res_valid  (res_valid),
    .dot_value  (dot_value),
    .overflowed (overflowed)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = dot_value;
  assign m_axis_tuser  = overflowed;

endmodule

// ===== src/q4bdp_lane.sv =====
// One multiply lane: a 4-bit weight (offset by eight) times a Q4.12
// activation, registered. Depends on q4bdp_pkg.
module q4bdp_lane (
  input  logic                                clk,
  input  logic                                ce,
  input  logic                                lane_valid,
  input  logic [q4bdp_pkg::NIB_W-1:0]         nibble,
  input  logic signed [q4bdp_pkg::ACT_W-1:0]  act,
  output logic signed [q4bdp_pkg::PROD_W-1:0] prod
);
  import q4bdp_pkg::*;

  logic signed [NIB_W:0]  weight;
  logic signed [PROD_W:0] full_prod;

  assign weight    = $signed({1'b0, nibble}) - $signed({1'b0, WEIGHT_OFFSET});
  assign full_prod = weight * act;

  // Elements past the length contribute zero.
  always_ff @(posedge clk) begin
    if (ce) begin
      prod <= lane_valid ? full_prod[PROD_W-1:0] : '0;
    end
  end

endmodule

// ===== src/q4bdp_merge.sv =====
// Merge stage: sums the lane products and scales the sum by the block
// scale, registered. Depends on q4bdp_pkg.
module q4bdp_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        ce,
  input  logic signed [q4bdp_pkg::PROD_W-1:0]         lane_prod [q4bdp_pkg::LANES],
  input  logic signed [q4bdp_pkg::SCALE_W-1:0]        scale,
  input  q4bdp_pkg::ctrl_t                            ctrl_in,
  output logic signed [q4bdp_pkg::TERM_W-1:0]         term,
  output q4bdp_pkg::ctrl_t                            ctrl_out
);
  import q4bdp_pkg::*;

  logic signed [PART_W-1:0] part;

  always_comb begin
    part = '0;
    for (int i = 0; i < LANES; i++) begin
      part = part + PART_W'(lane_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      term <= part * scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (ce) begin
      ctrl_out <= ctrl_in;
    end
  end

endmodule

// ===== src/q4bdp_accum.sv =====
// Saturating 64-bit accumulator with the result register.
// Depends on q4bdp_pkg.
module q4bdp_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ce,
  input  logic signed [q4bdp_pkg::TERM_W-1:0]  term,
  input  q4bdp_pkg::ctrl_t                     ctrl_in,
  output logic                                 res_valid,
  output logic [q4bdp_pkg::ACC_W-1:0]          dot_value,
  output logic                                 overflowed
);
  import q4bdp_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic                    sat;
  logic                    sat_next;
  logic signed [ACC_W:0]   sum;

  assign sum = {acc[ACC_W-1], acc} + (ACC_W + 1)'(term);

  always_comb begin
    acc_next = acc;
    sat_next = sat;
    if (ctrl_in.valid) begin
      sat_next = sat | ctrl_in.flag;
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        sat_next = 1'b1;
      end else begin
        acc_next = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sat       <= 1'b0;
      res_valid <= 1'b0;
    end else if (ce) begin
      res_valid <= ctrl_in.valid & ctrl_in.last;
      if (ctrl_in.valid && ctrl_in.last) begin
        acc <= '0;
        sat <= 1'b0;
      end else begin
        acc <= acc_next;
        sat <= sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce && ctrl_in.valid && ctrl_in.last) begin
      dot_value  <= acc_next;
      overflowed <= sat_next;
    end
  end

endmodule
